// ===== rtl/crae_pkg.sv =====
// ----------------------------------------------------------------------------
// crae_pkg
// Shared types, opcodes and sizes for the compact register ALU execute block.
// ----------------------------------------------------------------------------
package crae_pkg;

  localparam int NUM_REGS    = 8;
  localparam int REG_AW      = $clog2(NUM_REGS);
  localparam int DATA_W      = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 72;
  localparam int M_TUSER_W = 2;

  // sub-opcodes
  localparam logic [4:0] OP_SUB   = 5'd2;
  localparam logic [4:0] OP_AND   = 5'd4;
  localparam logic [4:0] OP_OR    = 5'd5;
  localparam logic [4:0] OP_BIC   = 5'd6;
  localparam logic [4:0] OP_XOR   = 5'd7;
  localparam logic [4:0] OP_TST   = 5'd11;
  localparam logic [4:0] OP_MUL64 = 5'd12;
  localparam logic [4:0] OP_SEXB  = 5'd13;
  localparam logic [4:0] OP_SEXW  = 5'd14;
  localparam logic [4:0] OP_EXTB  = 5'd15;
  localparam logic [4:0] OP_EXTW  = 5'd16;
  localparam logic [4:0] OP_ABS   = 5'd17;
  localparam logic [4:0] OP_NOT   = 5'd18;
  localparam logic [4:0] OP_NEG   = 5'd19;
  localparam logic [4:0] OP_ADD1  = 5'd20;
  localparam logic [4:0] OP_ADD2  = 5'd21;
  localparam logic [4:0] OP_ADD3  = 5'd22;
  localparam logic [4:0] OP_ASLV  = 5'd24;
  localparam logic [4:0] OP_LSRV  = 5'd25;
  localparam logic [4:0] OP_ASRV  = 5'd26;
  localparam logic [4:0] OP_ASL1  = 5'd27;
  localparam logic [4:0] OP_ASR1  = 5'd28;
  localparam logic [4:0] OP_LSR1  = 5'd29;
  localparam logic [4:0] OP_TRAP  = 5'd30;
  localparam logic [4:0] OP_BRK   = 5'd31;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TRAP    = 2'd1;
  localparam logic [1:0] ST_BREAK   = 2'd2;
  localparam logic [1:0] ST_ILLEGAL = 2'd3;

  typedef enum logic [4:0] {
    CLS_NONE, CLS_SUB, CLS_AND, CLS_OR, CLS_BIC, CLS_XOR, CLS_TST, CLS_MUL,
    CLS_SEXB, CLS_SEXW, CLS_EXTB, CLS_EXTW, CLS_ABS, CLS_NOT, CLS_NEG,
    CLS_ADD1, CLS_ADD2, CLS_ADD3, CLS_ASLV, CLS_LSRV, CLS_ASRV,
    CLS_ASL1, CLS_ASR1, CLS_LSR1
  } alu_class_t;

  // one decoded instruction waiting for the back end
  typedef struct packed {
    alu_class_t          cls;
    logic [REG_AW-1:0]   reg_b;
    logic [REG_AW-1:0]   reg_c;
    logic                writes;
    logic [1:0]          status;
    logic [DATA_W-1:0]   next_pc;
  } item_t;

  // one finished result
  typedef struct packed {
    logic [DATA_W-1:0] next_pc;
    logic [DATA_W-1:0] write_value;
    logic              write_done;
    logic              zero_flag;
    logic              negative_flag;
    logic [1:0]        status;
  } result_t;

endpackage

// ===== rtl/crae_ram.sv =====
// ----------------------------------------------------------------------------
// crae_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module crae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read-first: a same-cycle write is not seen
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== rtl/crae_front.sv =====
// ----------------------------------------------------------------------------
// crae_front
// Accepts instruction beats, decodes the sub-opcode into an operation class
// and parks the decoded item in a short queue for the back end.
// ----------------------------------------------------------------------------
module crae_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [crae_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  output logic                             q_valid,
  input  logic                             q_pop,
  output crae_pkg::item_t                  q_item
);
  import crae_pkg::*;

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t          slots [QUEUE_DEPTH];
  logic [QW-1:0]  wr_ptr;
  logic [QW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;
  item_t          dec;
  logic [4:0]     opcode;
  logic           push;

  assign opcode = s_axis_tdata[4:0];

  always_comb begin
    dec.reg_b   = s_axis_tdata[5 +: REG_AW];
    dec.reg_c   = s_axis_tdata[8 +: REG_AW];
    dec.next_pc = s_axis_tdata[11 +: DATA_W] + DATA_W'(2);
    dec.writes  = 1'b1;
    dec.status  = ST_OK;
    dec.cls     = CLS_NONE;
    unique case (opcode)
      OP_SUB:   dec.cls = CLS_SUB;
      OP_AND:   dec.cls = CLS_AND;
      OP_OR:    dec.cls = CLS_OR;
      OP_BIC:   dec.cls = CLS_BIC;
      OP_XOR:   dec.cls = CLS_XOR;
      OP_TST: begin
        dec.cls    = CLS_TST;
        dec.writes = 1'b0;
      end
      OP_MUL64: begin
        dec.cls    = CLS_MUL;
        dec.writes = 1'b0;
      end
      OP_SEXB:  dec.cls = CLS_SEXB;
      OP_SEXW:  dec.cls = CLS_SEXW;
      OP_EXTB:  dec.cls = CLS_EXTB;
      OP_EXTW:  dec.cls = CLS_EXTW;
      OP_ABS:   dec.cls = CLS_ABS;
      OP_NOT:   dec.cls = CLS_NOT;
      OP_NEG:   dec.cls = CLS_NEG;
      OP_ADD1:  dec.cls = CLS_ADD1;
      OP_ADD2:  dec.cls = CLS_ADD2;
      OP_ADD3:  dec.cls = CLS_ADD3;
      OP_ASLV:  dec.cls = CLS_ASLV;
      OP_LSRV:  dec.cls = CLS_LSRV;
      OP_ASRV:  dec.cls = CLS_ASRV;
      OP_ASL1:  dec.cls = CLS_ASL1;
      OP_ASR1:  dec.cls = CLS_ASR1;
      OP_LSR1:  dec.cls = CLS_LSR1;
      OP_TRAP: begin
        dec.writes = 1'b0;
        dec.status = ST_TRAP;
      end
      OP_BRK: begin
        dec.writes = 1'b0;
        dec.status = ST_BREAK;
      end
      default: begin
        dec.writes = 1'b0;
        dec.status = ST_ILLEGAL;
      end
    endcase
  end

  assign s_axis_tready = (count != CW'(QUEUE_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (count != '0);
  assign q_item        = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !q_pop) begin
      count_next = count + CW'(1);
    end else if (q_pop && !push) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QW'(1);
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= dec;
    end
  end

endmodule

// ===== rtl/crae_back.sv =====
// ----------------------------------------------------------------------------
// crae_back
// Reads operands from the register file, executes one decoded item per
// cycle while the result beat is not held, updates flags and multiply registers, and holds the result beat.
// ----------------------------------------------------------------------------
module crae_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_pop,
  input  crae_pkg::item_t     q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output crae_pkg::result_t   out_result
);
  import crae_pkg::*;

  // execute stage
  logic                ex_valid;
  item_t               ex;
  logic                ex_b_init;
  logic                ex_c_init;
  logic                ex_fire;
  logic                slot_free;

  // register file and its reset-state bits
  logic [NUM_REGS-1:0] reg_init;
  logic [DATA_W-1:0]   rd_b;
  logic [DATA_W-1:0]   rd_c;

  // latest register write, covers the read-first gap
  logic                fw_valid;
  logic [REG_AW-1:0]   fw_addr;
  logic [DATA_W-1:0]   fw_data;

  logic [DATA_W-1:0]   op_b;
  logic [DATA_W-1:0]   op_c;
  logic [4:0]          sh;
  logic [DATA_W-1:0]   res;
  logic [DATA_W-1:0]   tst_and;
  logic signed [2*DATA_W-1:0] prod;

  logic                flag_z;
  logic                flag_n;
  logic [DATA_W-1:0]   mul_low;
  logic [DATA_W-1:0]   mul_middle;
  logic [DATA_W-1:0]   mul_high;

  logic                do_write;
  logic                is_tst;

  assign slot_free = !out_valid || out_ready;
  assign ex_fire   = ex_valid && slot_free;
  assign q_pop     = q_valid && (!ex_valid || ex_fire);
  assign do_write  = ex_fire && ex.writes;
  assign is_tst    = (ex.cls == CLS_TST);

  crae_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NUM_REGS)
  ) u_regfile (
    .clk     (clk),
    .we      (do_write),
    .waddr   (ex.reg_b),
    .wdata   (res),
    .re      (q_pop),
    .raddr_a (q_item.reg_b),
    .raddr_b (q_item.reg_c),
    .rdata_a (rd_b),
    .rdata_b (rd_c)
  );

  always_comb begin
    if (fw_valid && fw_addr == ex.reg_b) begin
      op_b = fw_data;
    end else begin
      op_b = ex_b_init ? rd_b : '0;
    end
    if (fw_valid && fw_addr == ex.reg_c) begin
      op_c = fw_data;
    end else begin
      op_c = ex_c_init ? rd_c : '0;
    end
  end

  assign sh      = op_c[4:0];
  assign tst_and = op_b & op_c;
  assign prod    = $signed(op_b) * $signed(op_c);

  always_comb begin
    res = '0;
    unique case (ex.cls)
      CLS_SUB:  res = op_b - op_c;
      CLS_AND:  res = op_b & op_c;
      CLS_OR:   res = op_b | op_c;
      CLS_BIC:  res = op_b & ~op_c;
      CLS_XOR:  res = op_b ^ op_c;
      CLS_SEXB: res = {{24{op_c[7]}}, op_c[7:0]};
      CLS_SEXW: res = {{16{op_c[15]}}, op_c[15:0]};
      CLS_EXTB: res = {24'd0, op_c[7:0]};
      CLS_EXTW: res = {16'd0, op_c[15:0]};
      CLS_ABS:  res = op_c[DATA_W-1] ? (DATA_W'(0) - op_c) : op_c;
      CLS_NOT:  res = ~op_c;
      CLS_NEG:  res = DATA_W'(0) - op_c;
      CLS_ADD1: res = op_b + {op_c[DATA_W-2:0], 1'b0};
      CLS_ADD2: res = op_b + {op_c[DATA_W-3:0], 2'b0};
      CLS_ADD3: res = op_b + {op_c[DATA_W-4:0], 3'b0};
      CLS_ASLV: res = op_b << sh;
      CLS_LSRV: res = op_b >> sh;
      CLS_ASRV: res = $unsigned($signed(op_b) >>> sh);
      CLS_ASL1: res = {op_c[DATA_W-2:0], 1'b0};
      CLS_ASR1: res = {op_c[DATA_W-1], op_c[DATA_W-1:1]};
      CLS_LSR1: res = {1'b0, op_c[DATA_W-1:1]};
      default:  res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid  <= 1'b0;
      out_valid <= 1'b0;
      reg_init  <= '0;
      fw_valid  <= 1'b0;
      flag_z    <= 1'b0;
      flag_n    <= 1'b0;
    end else begin
      if (q_pop) begin
        ex_valid <= 1'b1;
      end else if (ex_fire) begin
        ex_valid <= 1'b0;
      end
      if (ex_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (do_write) begin
        reg_init[ex.reg_b] <= 1'b1;
        fw_valid           <= 1'b1;
      end
      if (ex_fire && is_tst) begin
        flag_z <= (tst_and == '0);
        flag_n <= tst_and[DATA_W-1];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ex        <= q_item;
      ex_b_init <= reg_init[q_item.reg_b];
      ex_c_init <= reg_init[q_item.reg_c];
    end
    if (do_write) begin
      fw_addr <= ex.reg_b;
      fw_data <= res;
    end
    if (rst) begin
      mul_low    <= '0;
      mul_middle <= '0;
      mul_high   <= '0;
    end else if (ex_fire && ex.cls == CLS_MUL) begin
      mul_low    <= prod[DATA_W-1:0];
      mul_middle <= prod[DATA_W+15:16];
      mul_high   <= prod[2*DATA_W-1:DATA_W];
    end
    if (ex_fire) begin
      out_result.next_pc       <= ex.next_pc;
      out_result.write_value   <= ex.writes ? res : '0;
      out_result.write_done    <= ex.writes;
      out_result.zero_flag     <= is_tst ? (tst_and == '0) : flag_z;
      out_result.negative_flag <= is_tst ? tst_and[DATA_W-1] : flag_n;
      out_result.status        <= ex.status;
    end
  end

endmodule

// ===== rtl/compact_register_alu_execute.sv =====
// ----------------------------------------------------------------------------
// compact_register_alu_execute
// Execute stage for 16-bit compact register-register ALU instructions.
// ----------------------------------------------------------------------------
// The block takes one instruction beat per clock and returns one result beat
// per instruction, in order, at a sustained rate of one per clock while the
// result side does not stall. An accepted beat waits in the decode queue,
// leaves it with the registered register-file read, and passes through the
// ALU or the 32x32 multiplier into the output register. Backpressure on the
// result side fills the two-entry decode queue before the input side stalls.
// After reset all registers and flags read as zero.
module compact_register_alu_execute (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // opcode[4:0], reg_b[7:5], reg_c[10:8], pc_now[42:11], zero pad
  input  logic [crae_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // next_pc[31:0], write_value[63:32], write_done[64], zero_flag[65],
  // negative_flag[66], zero pad
  output logic [crae_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // status[1:0]
  output logic [crae_pkg::M_TUSER_W-1:0]   m_axis_tuser
);
  import crae_pkg::*;

  logic    q_valid;
  logic    q_pop;
  item_t   q_item;
  result_t result;

  crae_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_item        (q_item)
  );

  crae_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (result)
  );

  assign m_axis_tdata = {5'd0, result.negative_flag, result.zero_flag,
                         result.write_done, result.write_value, result.next_pc};
  assign m_axis_tuser = result.status;

  // the back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty decode queue");

  // a register write only comes from an executed instruction
  a_write_ok: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && result.write_done) |-> (result.status == ST_OK))
    else $error("register write with non-ok status");

  // no write means a zero write value
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !result.write_done) |-> (result.write_value == '0))
    else $error("write value set without a write");

  // an item popped now is in execute next cycle, so a result follows
  a_pop_then_busy: assert property (@(posedge clk) disable iff (rst)
    (q_pop && !m_axis_tvalid) |=> ##1 m_axis_tvalid)
    else $error("popped item produced no result");

endmodule

// ===== bench/tb_compact_register_alu_execute.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_compact_register_alu_execute
// Drives compact register-register instructions into the execute block and
// checks every result beat against a typed expectation or an in-bench model
// of the register file and flags. A short directed table comes first, then
// random instruction streams with bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module tb_compact_register_alu_execute;
  import crae_pkg::*;

  // sub-opcodes outside the group
  localparam logic [4:0] OP_NONE0  = 5'd0;
  localparam logic [4:0] OP_NONE1  = 5'd1;
  localparam logic [4:0] OP_NONE3  = 5'd3;
  localparam logic [4:0] OP_NONE8  = 5'd8;
  localparam logic [4:0] OP_NONE9  = 5'd9;
  localparam logic [4:0] OP_NONE10 = 5'd10;
  localparam logic [4:0] OP_NONE23 = 5'd23;

  localparam int RANDOM_INSTRS = 1550;
  localparam int HOLD_AFTER    = 500;
  localparam int HOLD_CYCLES   = 120;

  typedef struct packed {
    logic [4:0]  op;
    logic [2:0]  b;
    logic [2:0]  c;
    logic [31:0] pc;
    logic        typed;
    result_t     want;
  } instr_row_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;

  // model state
  logic [31:0] gpr [NUM_REGS];
  logic [31:0] mac_lo, mac_mid, mac_hi;
  logic        z_flag, n_flag;

  result_t     pending_results [$];
  instr_row_t  directed_rows [$];
  int          errors = 0;
  int          results_seen = 0;
  int          burst_left = 0;

  compact_register_alu_execute dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic in_group(input logic [4:0] op);
    case (op)
      OP_NONE0, OP_NONE1, OP_NONE3, OP_NONE8, OP_NONE9, OP_NONE10, OP_NONE23:
        return 1'b0;
      default:
        return 1'b1;
    endcase
  endfunction

  // executes one instruction on the model state and returns its result beat
  function automatic result_t retire_instr(input logic [4:0] op, input logic [2:0] bi,
                                           input logic [2:0] ci, input logic [31:0] pc);
    logic [31:0]        b, c, res;
    logic [4:0]         sh;
    logic               wr;
    logic [1:0]         st;
    logic signed [63:0] prod;
    result_t            r;
    b   = gpr[bi];
    c   = gpr[ci];
    sh  = c[4:0];
    res = '0;
    wr  = 1'b1;
    st  = ST_OK;
    case (op)
      OP_SUB:   res = b - c;
      OP_AND:   res = b & c;
      OP_OR:    res = b | c;
      OP_BIC:   res = b & ~c;
      OP_XOR:   res = b ^ c;
      OP_TST: begin
        z_flag = ((b & c) == '0);
        n_flag = b[31] & c[31];
        wr = 1'b0;
      end
      OP_MUL64: begin
        prod    = $signed({{32{b[31]}}, b}) * $signed({{32{c[31]}}, c});
        mac_lo  = prod[31:0];
        mac_mid = prod[47:16];
        mac_hi  = prod[63:32];
        wr = 1'b0;
      end
      OP_SEXB:  res = {{24{c[7]}}, c[7:0]};
      OP_SEXW:  res = {{16{c[15]}}, c[15:0]};
      OP_EXTB:  res = {24'h0, c[7:0]};
      OP_EXTW:  res = {16'h0, c[15:0]};
      OP_ABS:   res = c[31] ? -c : c;
      OP_NOT:   res = ~c;
      OP_NEG:   res = -c;
      OP_ADD1:  res = b + (c << 1);
      OP_ADD2:  res = b + (c << 2);
      OP_ADD3:  res = b + (c << 3);
      OP_ASLV:  res = b << sh;
      OP_LSRV:  res = b >> sh;
      OP_ASRV:  res = $signed(b) >>> sh;
      OP_ASL1:  res = c << 1;
      OP_ASR1:  res = {c[31], c[31:1]};
      OP_LSR1:  res = c >> 1;
      OP_TRAP: begin
        wr = 1'b0;
        st = ST_TRAP;
      end
      OP_BRK: begin
        wr = 1'b0;
        st = ST_BREAK;
      end
      default: begin
        wr = 1'b0;
        st = ST_ILLEGAL;
      end
    endcase
    if (wr) gpr[bi] = res;
    else res = '0;
    r.next_pc       = pc + 32'd2;
    r.write_value   = res;
    r.write_done    = wr;
    r.zero_flag     = z_flag;
    r.negative_flag = n_flag;
    r.status        = st;
    return r;
  endfunction

  task automatic add_row(input logic [4:0] op, input logic [2:0] b, input logic [2:0] c,
                         input logic [31:0] pc, input logic typed, input result_t want);
    instr_row_t row;
    row.op    = op;
    row.b     = b;
    row.c     = c;
    row.pc    = pc;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // drives one instruction beat, waits for it to be taken, then maybe idles
  task automatic send_instr(input logic [4:0] op, input logic [2:0] b, input logic [2:0] c,
                            input logic [31:0] pc, input logic typed, input result_t want);
    result_t predicted;
    int      gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, pc, c, b, op};
    do @(posedge clk); while (!s_axis_tready);
    predicted = retire_instr(op, b, c, pc);
    pending_results.push_back(typed ? want : predicted);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                              : $urandom_range(0, 24);
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // result side: compare every beat with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none actual %h/%h", $time,
                 m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("next_pc", want.next_pc, m_axis_tdata[31:0]);
        check_field("write_value", want.write_value, m_axis_tdata[63:32]);
        check_field("write_done", 32'(want.write_done), 32'(m_axis_tdata[64]));
        check_field("zero_flag", 32'(want.zero_flag), 32'(m_axis_tdata[65]));
        check_field("negative_flag", 32'(want.negative_flag), 32'(m_axis_tdata[66]));
        check_field("status", 32'(want.status), 32'(m_axis_tuser));
      end
    end
  end

  // result side stalls: a randomly picked ready mode, plus one long hold
  initial begin
    int mode;
    int cyc;
    int hold_left;
    bit hold_done;
    mode      = 0;
    cyc       = 0;
    hold_left = 0;
    hold_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (cyc % 50 == 0) mode = $urandom_range(0, 3);
      cyc++;
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 1) == 0);
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
      @(posedge clk);
    end
  end

  initial begin
    logic [4:0] op;
    int         wait_cycles;
    foreach (gpr[i]) gpr[i] = '0;
    mac_lo  = '0;
    mac_mid = '0;
    mac_hi  = '0;
    z_flag  = 1'b0;
    n_flag  = 1'b0;

    // values right after reset, the sign-bit corner cases and trap codes
    add_row(OP_TRAP,  0, 0, 32'hffff_fffe, 1, {32'h0, 32'h0, 3'b000, ST_TRAP});
    add_row(OP_BRK,   7, 7, 32'hffff_ffff, 1, {32'h1, 32'h0, 3'b000, ST_BREAK});
    add_row(OP_NONE0, 3, 4, 32'h0000_0000, 1, {32'h2, 32'h0, 3'b000, ST_ILLEGAL});
    add_row(OP_TST,   0, 1, 32'h100, 1, {32'h102, 32'h0, 3'b010, ST_OK});
    add_row(OP_NOT,   1, 0, 32'h104, 1, {32'h106, 32'hffff_ffff, 3'b110, ST_OK});
    // shift by 31 taken from an all-ones register
    add_row(OP_ASLV,  1, 1, 32'h108, 1, {32'h10a, 32'h8000_0000, 3'b110, ST_OK});
    add_row(OP_ABS,   3, 1, 32'h10c, 1, {32'h10e, 32'h8000_0000, 3'b110, ST_OK});
    add_row(OP_TST,   1, 3, 32'h110, 1, {32'h112, 32'h0, 3'b001, ST_OK});
    add_row(OP_MUL64, 1, 1, 32'h114, 1, {32'h116, 32'h0, 3'b001, ST_OK});
    add_row(OP_NEG,   4, 1, 32'h118, 1, {32'h11a, 32'h8000_0000, 3'b101, ST_OK});
    add_row(OP_NOT,   2, 0, 32'h11c, 1, {32'h11e, 32'hffff_ffff, 3'b101, ST_OK});
    add_row(OP_LSR1,  5, 2, 32'h8000_0000, 0, '0);
    add_row(OP_ASR1,  6, 1, 32'h7fff_fffe, 0, '0);
    add_row(OP_ASL1,  7, 5, 32'h5555_5554, 0, '0);
    add_row(OP_SEXB,  0, 7, 32'haaaa_aaaa, 0, '0);
    add_row(OP_SEXW,  0, 5, 32'h200, 0, '0);
    add_row(OP_EXTB,  6, 7, 32'h204, 0, '0);
    add_row(OP_EXTW,  3, 2, 32'h208, 0, '0);
    add_row(OP_SUB,   2, 5, 32'h20c, 0, '0);
    add_row(OP_AND,   1, 7, 32'h210, 0, '0);
    add_row(OP_OR,    3, 5, 32'h214, 0, '0);
    add_row(OP_BIC,   5, 6, 32'h218, 0, '0);
    add_row(OP_XOR,   6, 7, 32'h21c, 0, '0);
    add_row(OP_ADD1,  4, 5, 32'h220, 0, '0);
    add_row(OP_ADD2,  4, 6, 32'h224, 0, '0);
    add_row(OP_ADD3,  4, 7, 32'h228, 0, '0);
    add_row(OP_LSRV,  7, 6, 32'h22c, 0, '0);
    add_row(OP_ASRV,  1, 5, 32'h230, 0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_instr(directed_rows[i].op, directed_rows[i].b, directed_rows[i].c,
                 directed_rows[i].pc, directed_rows[i].typed, directed_rows[i].want);

    for (int n = 0; n < RANDOM_INSTRS; n++) begin
      // lean on ops that stir register contents, keep out-of-group codes rare
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 5))
          0:       op = OP_NOT;
          1:       op = OP_NEG;
          2:       op = OP_ADD3;
          3:       op = OP_XOR;
          4:       op = OP_SUB;
          default: op = OP_ADD1;
        endcase
      end else begin
        do op = 5'($urandom_range(0, 31));
        while (!in_group(op) && $urandom_range(0, 4) != 0);
      end
      send_instr(op, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom, 0, '0);
    end
    s_axis_tvalid <= 1'b0;

    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);

    if (errors == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      if (pending_results.size() != 0)
        $display("%0t: %0d results never arrived", $time, pending_results.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
